// ===== src/tfsa_pkg.sv =====
// ---------------------------------------------------------------------------
// tfsa_pkg
// Types and constants shared by the tiled framebuffer sample address block.
// ---------------------------------------------------------------------------
package tfsa_pkg;

   // Configuration port geometry
   localparam int unsigned CSR_DATA_W  = 13;
   localparam int unsigned CSR_INDEX_W = 3;

   // Tile geometry in samples
   localparam int unsigned TILE_SAMPLES_X = 80;
   localparam int unsigned TILE_SAMPLES_Y = 16;
   localparam int unsigned TILE_HALF_X    = 40;

   // Exact floor(v / 80) for v below 2^18: (v * DIV80_MUL) >> DIV80_SHIFT
   localparam int unsigned DIV80_MUL   = 52429;
   localparam int unsigned DIV80_SHIFT = 22;

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIRST_TILE     = 3'd0,
      CSR_ROW_PITCH      = 3'd1,
      CSR_SURFACE_HEIGHT = 3'd2,
      CSR_MSAA_MODE      = 3'd3,
      CSR_WIDE_PIXELS    = 3'd4,
      CSR_DEPTH_SURFACE  = 3'd5
   } csr_index_type;

   // Multisample modes
   typedef enum logic [1:0] {
      MSAA_1X  = 2'd0,
      MSAA_2X  = 2'd1,
      MSAA_4X  = 2'd2,
      MSAA_BAD = 2'd3
   } msaa_type;

   // Surface layout as held in the configuration registers
   typedef struct packed {
      logic [10:0] first_tile;
      logic [12:0] row_pitch;
      logic [12:0] surface_height;
      msaa_type    msaa_mode;
      logic        wide_pixels;
      logic        depth_surface;
   } cfg_type;

   // Item after the coordinate stages: word in tile and unreduced tile number
   typedef struct packed {
      logic        ok;
      logic        wide;
      logic [10:0] word;
      logic [19:0] sum;
   } mid_type;

   // Item fields that ride along with the reduced tile number
   typedef struct packed {
      logic        ok;
      logic        wide;
      logic [10:0] word;
   } tail_type;

endpackage

// ===== src/tfsa_if.sv =====
// ---------------------------------------------------------------------------
// tfsa_req_if / tfsa_rsp_if
// Valid/ready channels for sample requests and address results.
// ---------------------------------------------------------------------------
interface tfsa_req_if;
   logic        valid;
   logic        ready;
   logic [12:0] pixel_x;
   logic [12:0] pixel_y;
   logic [1:0]  sample_index;

   modport source (output valid, pixel_x, pixel_y, sample_index, input ready);
   modport sink   (input valid, pixel_x, pixel_y, sample_index, output ready);
endinterface

interface tfsa_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [23:0] low_address;
   logic        dual_word;
   logic [23:0] high_address;

   modport source (output valid, ok, low_address, dual_word, high_address, input ready);
   modport sink   (input valid, ok, low_address, dual_word, high_address, output ready);
endinterface

// ===== src/tfsa_csr.sv =====
// ---------------------------------------------------------------------------
// tfsa_csr
// Surface layout registers, written through a plain index/data port.
// ---------------------------------------------------------------------------
module tfsa_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [tfsa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tfsa_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output tfsa_pkg::cfg_type                    cfg
);

   tfsa_pkg::cfg_type cfg_ff;
   tfsa_pkg::cfg_type cfg_in;

   // Decode the write, mask to register width, drop unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (tfsa_pkg::csr_index_type'(csr_index))
            tfsa_pkg::CSR_FIRST_TILE:     cfg_in.first_tile     = csr_write_data[10:0];
            tfsa_pkg::CSR_ROW_PITCH:      cfg_in.row_pitch      = csr_write_data[12:0];
            tfsa_pkg::CSR_SURFACE_HEIGHT: cfg_in.surface_height = csr_write_data[12:0];
            tfsa_pkg::CSR_MSAA_MODE:
               cfg_in.msaa_mode = tfsa_pkg::msaa_type'(csr_write_data[1:0]);
            tfsa_pkg::CSR_WIDE_PIXELS:    cfg_in.wide_pixels    = csr_write_data[0];
            tfsa_pkg::CSR_DEPTH_SURFACE:  cfg_in.depth_surface  = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/tfsa_coord.sv =====
// ---------------------------------------------------------------------------
// tfsa_coord
// Two stages: check the item, expand to sample coordinates, split by tile,
// then form the word inside the tile and the unreduced tile number.
// ---------------------------------------------------------------------------
module tfsa_coord (
   input  logic              clock,
   input  tfsa_pkg::cfg_type cfg,
   input  logic [12:0]       pixel_x,
   input  logic [12:0]       pixel_y,
   input  logic [1:0]        sample_index,
   input  logic [1:0]        load,
   output tfsa_pkg::mid_type mid
);

   // Stage 0 signals
   logic        ok0_in, ok0_ff;
   logic [13:0] sx0_in, sx0_ff;
   logic [13:0] sy0_in, sy0_ff;
   logic [7:0]  qx0_in, qx0_ff;
   logic [8:0]  rt0_in, rt0_ff;
   logic        sample_ok;
   logic [13:0] row_samples;
   logic [30:0] qx_prod;
   logic [30:0] rt_prod;
   logic [7:0]  tiles_per_row;

   // Stage 1 signals
   logic [6:0]        ix_raw;
   logic [6:0]        ix_swap;
   tfsa_pkg::mid_type mid_in, mid_ff;

   // Validate layout, coordinate and sample; expand to sample coordinates
   always_comb begin
      case (cfg.msaa_mode)
         tfsa_pkg::MSAA_1X: sample_ok = (sample_index == 2'd0);
         tfsa_pkg::MSAA_2X: sample_ok = !sample_index[1];
         tfsa_pkg::MSAA_4X: sample_ok = 1'b1;
         default:           sample_ok = 1'b0;
      endcase
      ok0_in = (cfg.row_pitch != 13'd0) && (cfg.surface_height != 13'd0) &&
               (pixel_x < cfg.row_pitch) && (pixel_y < cfg.surface_height) &&
               sample_ok;
      case (cfg.msaa_mode)
         tfsa_pkg::MSAA_4X: begin
            sx0_in      = {pixel_x, sample_index[0]};
            sy0_in      = {pixel_y, sample_index[1]};
            row_samples = {cfg.row_pitch, 1'b0};
         end
         tfsa_pkg::MSAA_2X: begin
            sx0_in      = {1'b0, pixel_x};
            sy0_in      = {pixel_y, sample_index[0]};
            row_samples = {1'b0, cfg.row_pitch};
         end
         default: begin
            sx0_in      = {1'b0, pixel_x};
            sy0_in      = {1'b0, pixel_y};
            row_samples = {1'b0, cfg.row_pitch};
         end
      endcase
      // Tile column and tiles per row by reciprocal multiply
      qx_prod       = 31'(sx0_in) * 31'(tfsa_pkg::DIV80_MUL);
      qx0_in        = 8'(qx_prod >> tfsa_pkg::DIV80_SHIFT);
      rt_prod       = (31'(row_samples) + 31'(tfsa_pkg::TILE_SAMPLES_X - 1)) *
                      31'(tfsa_pkg::DIV80_MUL);
      tiles_per_row = 8'(rt_prod >> tfsa_pkg::DIV80_SHIFT);
      rt0_in        = cfg.wide_pixels ? {tiles_per_row, 1'b0} : {1'b0, tiles_per_row};
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         ok0_ff <= ok0_in;
         sx0_ff <= sx0_in;
         sy0_ff <= sy0_in;
         qx0_ff <= qx0_in;
         rt0_ff <= rt0_in;
      end
   end

   // Word inside the tile with depth half swap; tile number before wrap
   always_comb begin
      ix_raw = 7'(sx0_ff - 14'(qx0_ff) * 14'(tfsa_pkg::TILE_SAMPLES_X));
      if (!cfg.depth_surface) begin
         ix_swap = ix_raw;
      end else if (ix_raw < 7'(tfsa_pkg::TILE_HALF_X)) begin
         ix_swap = ix_raw + 7'(tfsa_pkg::TILE_HALF_X);
      end else begin
         ix_swap = ix_raw - 7'(tfsa_pkg::TILE_HALF_X);
      end
      mid_in.ok   = ok0_ff;
      mid_in.wide = cfg.wide_pixels;
      mid_in.word = 11'(sy0_ff[3:0]) * 11'(tfsa_pkg::TILE_SAMPLES_X) + 11'(ix_swap);
      mid_in.sum  = 20'(cfg.first_tile) + 20'(sy0_ff[13:4]) * 20'(rt0_ff) +
                    (cfg.wide_pixels ? 20'({qx0_ff, 1'b0}) : 20'(qx0_ff));
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         mid_ff <= mid_in;
      end
   end

   assign mid = mid_ff;

endmodule

// ===== src/tfsa_wrap.sv =====
// ---------------------------------------------------------------------------
// tfsa_wrap
// Two stages: wrap the tile number modulo the tile count by reciprocal
// multiply, then back-multiply, subtract and correct once.
// ---------------------------------------------------------------------------
module tfsa_wrap #(
   parameter int unsigned NUM_TILES = 2048,
   localparam int unsigned TILE_W   = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1
) (
   input  logic               clock,
   input  logic [1:0]         load,
   input  tfsa_pkg::mid_type  mid,
   output logic [TILE_W-1:0]  tile,
   output tfsa_pkg::tail_type tail
);

   localparam logic [63:0] ONE_SHIFTED = 64'd1 << 32;
   localparam logic [32:0] RECIP       = 33'(ONE_SHIFTED / 64'(NUM_TILES));
   localparam logic [19:0] COUNT       = 20'(NUM_TILES);

   logic [52:0]        q_prod;
   logic [19:0]        q_in, q_ff;
   tfsa_pkg::mid_type  mid2_ff;
   logic [19:0]        rem_raw;
   logic [19:0]        rem_fix;
   logic [TILE_W-1:0]  tile_in, tile_ff;
   tfsa_pkg::tail_type tail_in, tail_ff;

   // Estimated quotient, at most one below the true one
   always_comb begin
      q_prod = 53'(mid.sum) * 53'(RECIP);
      q_in   = 20'(q_prod >> 32);
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         q_ff    <= q_in;
         mid2_ff <= mid;
      end
   end

   // Remainder with one correcting subtract
   always_comb begin
      rem_raw      = mid2_ff.sum - q_ff * COUNT;
      rem_fix      = (rem_raw >= COUNT) ? rem_raw - COUNT : rem_raw;
      tile_in      = TILE_W'(rem_fix);
      tail_in.ok   = mid2_ff.ok;
      tail_in.wide = mid2_ff.wide;
      tail_in.word = mid2_ff.word;
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         tile_ff <= tile_in;
         tail_ff <= tail_in;
      end
   end

   assign tile = tile_ff;
   assign tail = tail_ff;

endmodule

// ===== src/tfsa_addr.sv =====
// ---------------------------------------------------------------------------
// tfsa_addr
// Two stages: byte address of the low word, then the address in the next
// tile and the zeroing of rejected items into the output register.
// ---------------------------------------------------------------------------
module tfsa_addr #(
   parameter int unsigned NUM_TILES  = 2048,
   parameter int unsigned TILE_BYTES = 5120,
   localparam int unsigned TILE_W    = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1
) (
   input  logic               clock,
   input  logic [1:0]         load,
   input  logic [TILE_W-1:0]  tile,
   input  tfsa_pkg::tail_type tail,
   output logic               ok,
   output logic [23:0]        low_address,
   output logic               dual_word,
   output logic [23:0]        high_address
);

   localparam logic [TILE_W-1:0] LAST_TILE = TILE_W'(NUM_TILES - 1);
   localparam logic [23:0]       BYTES     = 24'(TILE_BYTES);

   logic [23:0]        low4_in, low4_ff;
   logic               last4_in, last4_ff;
   tfsa_pkg::tail_type tail4_ff;
   logic [23:0]        word_bytes;
   logic [23:0]        high_raw;
   logic               ok_ff;
   logic [23:0]        low_ff, high_ff;
   logic               dual_word_ff;

   // Low word address, wrapping at 24 bits
   always_comb begin
      low4_in  = 24'(tile) * BYTES + 24'({tail.word, 2'b00});
      last4_in = (tile == LAST_TILE);
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         low4_ff  <= low4_in;
         last4_ff <= last4_in;
         tail4_ff <= tail;
      end
   end

   // Next tile is one tile further, or tile zero after the last tile
   always_comb begin
      word_bytes = 24'({tail4_ff.word, 2'b00});
      high_raw   = last4_ff ? word_bytes : low4_ff + BYTES;
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         ok_ff        <= tail4_ff.ok;
         low_ff       <= tail4_ff.ok ? low4_ff : 24'd0;
         dual_word_ff <= tail4_ff.ok && tail4_ff.wide;
         high_ff      <= (tail4_ff.ok && tail4_ff.wide) ? high_raw : 24'd0;
      end
   end

   assign ok           = ok_ff;
   assign low_address  = low_ff;
   assign dual_word    = dual_word_ff;
   assign high_address = high_ff;

endmodule

// ===== src/tiled_framebuffer_sample_address.sv =====
// ---------------------------------------------------------------------------
// tiled_framebuffer_sample_address
// Pixel and sample to byte address mapping for a tiled framebuffer memory.
// ---------------------------------------------------------------------------
// Takes one request item per clock while the response side does not stall.
// The six register stages are: coordinate check and tile split, word and
// tile number, reciprocal estimate, modulo correction, low address,
// high address and output register. Each stage keeps its own valid bit and
// loads whenever it is empty or the stage after it moves, so a stalled
// response side holds every item in place while empty stages still fill.
// Program the layout registers only while no item is in flight; an invalid
// layout, coordinate or sample returns ok low with zero addresses.
module tiled_framebuffer_sample_address #(
   parameter int unsigned NUM_TILES  = 2048,
   parameter int unsigned TILE_BYTES = 5120
) (
   input  logic                             clock,
   input  logic                             reset,
   tfsa_req_if.sink                         req,
   tfsa_rsp_if.source                       rsp,
   input  logic                             csr_write_enable,
   input  logic [tfsa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tfsa_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   localparam int unsigned STAGES = 6;
   localparam int unsigned TILE_W = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;

   tfsa_pkg::cfg_type  cfg;
   tfsa_pkg::mid_type  mid;
   tfsa_pkg::tail_type tail;
   logic [TILE_W-1:0]  tile;
   logic [STAGES-1:0]  vld_ff, vld_in;
   logic [STAGES-1:0]  load;

   // Stage loads when empty or when its successor moves
   always_comb begin
      load[STAGES-1] = !vld_ff[STAGES-1] || rsp.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load[k] = !vld_ff[k] || load[k+1];
      end
   end

   // Advance valid bits with the data
   always_comb begin
      vld_in = vld_ff;
      for (int k = 0; k < STAGES; k++) begin
         if (load[k]) begin
            vld_in[k] = (k == 0) ? req.valid : vld_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req.ready = load[0];
   assign rsp.valid = vld_ff[STAGES-1];

   tfsa_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   tfsa_coord u_coord (
      .clock        (clock),
      .cfg          (cfg),
      .pixel_x      (req.pixel_x),
      .pixel_y      (req.pixel_y),
      .sample_index (req.sample_index),
      .load         (load[1:0]),
      .mid          (mid)
   );

   tfsa_wrap #(
      .NUM_TILES (NUM_TILES)
   ) u_wrap (
      .clock (clock),
      .load  (load[3:2]),
      .mid   (mid),
      .tile  (tile),
      .tail  (tail)
   );

   tfsa_addr #(
      .NUM_TILES  (NUM_TILES),
      .TILE_BYTES (TILE_BYTES)
   ) u_addr (
      .clock        (clock),
      .load         (load[5:4]),
      .tile         (tile),
      .tail         (tail),
      .ok           (rsp.ok),
      .low_address  (rsp.low_address),
      .dual_word    (rsp.dual_word),
      .high_address (rsp.high_address)
   );

`ifndef NO_ASSERTIONS
   // Rejected items carry no addresses
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ok |->
         rsp.low_address == 24'd0 && rsp.high_address == 24'd0 && !rsp.dual_word)
      else $error("rejected item with nonzero address");

   // A second address only comes with an accepted item
   a_high_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.dual_word |-> rsp.ok)
      else $error("high address on rejected item");

   // Narrow results leave the high address clear
   a_narrow_high_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ok && !rsp.dual_word |-> rsp.high_address == 24'd0)
      else $error("high address set without high word");

   // An accepted item occupies the first stage next cycle
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> vld_ff[0])
      else $error("accepted item lost at pipeline entry");
`endif

endmodule

// ===== sim/tiled_framebuffer_sample_address_checker.sv =====
// ---------------------------------------------------------------------------
// tiled_framebuffer_sample_address_checker
// Watches the request, result and register ports of the sample address
// block, predicts the address of every accepted request item and compares
// each result item with the oldest prediction, field by field.
// ---------------------------------------------------------------------------
module tiled_framebuffer_sample_address_checker #(
   parameter int unsigned NUM_TILES  = 2048,
   parameter int unsigned TILE_BYTES = 5120
) (
   input  logic                             clock,
   input  logic                             reset,
   tfsa_req_if                              req,
   tfsa_rsp_if                              rsp,
   input  logic                             csr_write_enable,
   input  logic [tfsa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tfsa_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                               mismatch_count,
   output int                               addresses_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WORD_BYTES = 4;

   typedef struct packed {
      logic        ok;
      logic [23:0] low_address;
      logic        dual_word;
      logic [23:0] high_address;
   } sample_address_type;

   tfsa_pkg::cfg_type  layout;
   sample_address_type pending_addresses[$];
   int                 mismatches = 0;

   // Map one pixel and sample to its word addresses under the given layout
   function automatic sample_address_type predict_sample_address(tfsa_pkg::cfg_type lay,
         logic [12:0] x, logic [12:0] y, logic [1:0] s);
      sample_address_type res;
      int unsigned        sx, sy, col, word, width, tiles_per_row, step;
      longint unsigned    tile, next_tile;
      res = '0;
      if (lay.row_pitch == 0 || lay.surface_height == 0 ||
          lay.msaa_mode == tfsa_pkg::MSAA_BAD)
         return res;
      if (x >= lay.row_pitch || y >= lay.surface_height)
         return res;
      if (int'(s) >= (1 << int'(lay.msaa_mode)))
         return res;

      // Expand the pixel to sample coordinates
      case (lay.msaa_mode)
         tfsa_pkg::MSAA_4X: begin
            sx = {x, s[0]};
            sy = {y, s[1]};
         end
         tfsa_pkg::MSAA_2X: begin
            sx = x;
            sy = {y, s[0]};
         end
         default: begin
            sx = x;
            sy = y;
         end
      endcase

      // Word within the tile, halves swapped on depth surfaces
      col = sx % tfsa_pkg::TILE_SAMPLES_X;
      if (lay.depth_surface)
         col = (col + tfsa_pkg::TILE_HALF_X) % tfsa_pkg::TILE_SAMPLES_X;
      word = (sy % tfsa_pkg::TILE_SAMPLES_Y) * tfsa_pkg::TILE_SAMPLES_X + col;

      // Tile number, wrapped over the tile memory
      width = lay.row_pitch;
      if (lay.msaa_mode == tfsa_pkg::MSAA_4X)
         width = width * 2;
      step = lay.wide_pixels ? 2 : 1;
      tiles_per_row = ((width + tfsa_pkg::TILE_SAMPLES_X - 1) / tfsa_pkg::TILE_SAMPLES_X)
                      * step;
      tile = longint'(lay.first_tile)
           + longint'(sy / tfsa_pkg::TILE_SAMPLES_Y) * tiles_per_row
           + longint'(sx / tfsa_pkg::TILE_SAMPLES_X) * step;
      tile = tile % NUM_TILES;

      res.ok = 1'b1;
      res.low_address = 24'(tile * TILE_BYTES + word * WORD_BYTES);
      if (lay.wide_pixels) begin
         next_tile = (tile + 1) % NUM_TILES;
         res.dual_word = 1'b1;
         res.high_address = 24'(next_tile * TILE_BYTES + word * WORD_BYTES);
      end
      return res;
   endfunction

   function automatic int field_mismatch(string field, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected 0x%06h actual 0x%06h", $time, field, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Track the layout, check result items, then queue new predictions
   always @(posedge clock) begin : monitor
      sample_address_type want, got;
      if (reset) begin
         layout <= '0;
         pending_addresses.delete();
         addresses_in_flight <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               tfsa_pkg::CSR_FIRST_TILE:
                  layout.first_tile     <= csr_write_data[10:0];
               tfsa_pkg::CSR_ROW_PITCH:
                  layout.row_pitch      <= csr_write_data[12:0];
               tfsa_pkg::CSR_SURFACE_HEIGHT:
                  layout.surface_height <= csr_write_data[12:0];
               tfsa_pkg::CSR_MSAA_MODE:
                  layout.msaa_mode      <= tfsa_pkg::msaa_type'(csr_write_data[1:0]);
               tfsa_pkg::CSR_WIDE_PIXELS:
                  layout.wide_pixels    <= csr_write_data[0];
               tfsa_pkg::CSR_DEPTH_SURFACE:
                  layout.depth_surface  <= csr_write_data[0];
               default: ;
            endcase
         end

         if (rsp.valid && rsp.ready) begin
            got.ok           = rsp.ok;
            got.low_address  = rsp.low_address;
            got.dual_word    = rsp.dual_word;
            got.high_address = rsp.high_address;
            if (pending_addresses.size() == 0) begin
               $display("%0t ns: unexpected result item, expected none actual %h", $time, got);
               mismatches++;
            end else begin
               want = pending_addresses.pop_front();
               mismatches += field_mismatch("ok", 24'(want.ok), 24'(got.ok));
               mismatches += field_mismatch("low_address", want.low_address, got.low_address);
               mismatches += field_mismatch("dual_word", 24'(want.dual_word),
                                            24'(got.dual_word));
               mismatches += field_mismatch("high_address", want.high_address,
                                            got.high_address);
            end
         end

         if (req.valid && req.ready)
            pending_addresses = {pending_addresses,
                                 predict_sample_address(layout, req.pixel_x,
                                                        req.pixel_y, req.sample_index)};

         addresses_in_flight <= pending_addresses.size();
      end
      mismatch_count <= mismatches;
   end

endmodule

// ===== sim/tiled_framebuffer_sample_address_tb.sv =====
// ---------------------------------------------------------------------------
// tiled_framebuffer_sample_address_tb
// Drives the sample address block through directed and random surface
// layouts, with bursty requests and a stalling result side, and reports
// the verdict from the checker's mismatch count and in-flight count.
// ---------------------------------------------------------------------------
module tiled_framebuffer_sample_address_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NUM_TILES        = 2048;
   localparam int unsigned TILE_BYTES       = 5120;
   localparam int unsigned RANDOM_PHASES    = 8;
   localparam int unsigned PHASE_SAMPLES    = 110;
   localparam int unsigned HOLD_PHASE       = 2;
   localparam int unsigned LONG_HOLD_CYCLES = 400;
   localparam int unsigned DRAIN_CYCLES     = 10;
   localparam int unsigned CYCLE_LIMIT      = 400000;
   localparam logic [tfsa_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_write_enable = 1'b0;
   logic [tfsa_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [tfsa_pkg::CSR_DATA_W-1:0]  csr_write_data = '0;
   int                               mismatch_count;
   int                               addresses_in_flight;
   int unsigned                      cycle_count = 0;
   int unsigned                      burst_left = 0;
   bit                               hold_armed = 1'b0;

   tfsa_req_if req_if();
   tfsa_rsp_if rsp_if();

   tiled_framebuffer_sample_address #(
      .NUM_TILES(NUM_TILES),
      .TILE_BYTES(TILE_BYTES)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   tiled_framebuffer_sample_address_checker #(
      .NUM_TILES(NUM_TILES),
      .TILE_BYTES(TILE_BYTES)
   ) u_checker (
      .clock               (clock),
      .reset               (reset),
      .req                 (req_if),
      .rsp                 (rsp_if),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .mismatch_count      (mismatch_count),
      .addresses_in_flight (addresses_in_flight)
   );

   always #5 clock = ~clock;

   // End the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tiled_framebuffer_sample_address_tb: FAIL");
         $finish;
      end
   end

   // Stall the result side in segments of varying density, once for a long stretch
   initial begin : receiver
      int unsigned seg_kind, seg_len;
      bit          hold_done;
      hold_done = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            seg_kind = $urandom_range(0, 3);
            seg_len  = $urandom_range(4, 40);
            repeat (seg_len) begin
               case (seg_kind)
                  0: rsp_if.ready <= 1'b1;
                  1: rsp_if.ready <= 1'($urandom_range(0, 1));
                  2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_if.ready <= ($urandom_range(0, 3) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   task automatic write_register(logic [tfsa_pkg::CSR_INDEX_W-1:0] index,
                                 logic [tfsa_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // Write every layout register; unused upper data bits carry junk
   task automatic program_layout(logic [10:0] base, logic [12:0] pitch, logic [12:0] height,
                                 tfsa_pkg::msaa_type mode, logic wide, logic depth);
      write_register(tfsa_pkg::CSR_FIRST_TILE, {2'($urandom), base});
      write_register(tfsa_pkg::CSR_ROW_PITCH, pitch);
      write_register(tfsa_pkg::CSR_SURFACE_HEIGHT, height);
      write_register(tfsa_pkg::CSR_MSAA_MODE, {11'($urandom), mode});
      write_register(tfsa_pkg::CSR_WIDE_PIXELS, {12'($urandom), wide});
      write_register(tfsa_pkg::CSR_DEPTH_SURFACE, {12'($urandom), depth});
      csr_write_enable <= 1'b0;
   endtask

   // Offer one item in bursts separated by random gaps, hold until accepted
   task automatic send_sample(logic [12:0] x, logic [12:0] y, logic [1:0] s);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 10);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_if.valid        <= 1'b1;
      req_if.pixel_x      <= x;
      req_if.pixel_y      <= y;
      req_if.sample_index <= s;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      burst_left--;
   endtask

   // Drop valid and wait until every result item is back
   task automatic drain;
      req_if.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (addresses_in_flight != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [10:0]        base;
      logic [12:0]        pitch, height, x, y;
      logic [1:0]         s;
      tfsa_pkg::msaa_type mode;
      logic               wide, depth;

      req_if.valid        = 1'b0;
      req_if.pixel_x      = '0;
      req_if.pixel_y      = '0;
      req_if.sample_index = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Largest surface, last base tile: 4x, wide, depth, tile wrap
      program_layout(11'd2047, 13'd8191, 13'd8191, tfsa_pkg::MSAA_4X, 1'b1, 1'b1);
      send_sample(13'd0, 13'd0, 2'd0);
      send_sample(13'd0, 13'd0, 2'd3);
      send_sample(13'd8190, 13'd8190, 2'd3);
      send_sample(13'd8190, 13'd8190, 2'd1);
      send_sample(13'd8191, 13'd0, 2'd0);
      send_sample(13'd0, 13'd8191, 2'd2);
      send_sample(13'd4095, 13'd4096, 2'd2);
      drain();

      // Single pixel surface: sample and coordinate out of range
      program_layout(11'd0, 13'd1, 13'd1, tfsa_pkg::MSAA_1X, 1'b0, 1'b0);
      send_sample(13'd0, 13'd0, 2'd0);
      send_sample(13'd0, 13'd0, 2'd1);
      send_sample(13'd1, 13'd0, 2'd0);
      send_sample(13'd8191, 13'd8191, 2'd3);
      drain();

      // 2x wide surface across tile edges, sample out of range
      program_layout(11'd100, 13'd640, 13'd480, tfsa_pkg::MSAA_2X, 1'b1, 1'b0);
      send_sample(13'd639, 13'd479, 2'd1);
      send_sample(13'd79, 13'd15, 2'd0);
      send_sample(13'd80, 13'd16, 2'd1);
      send_sample(13'd0, 13'd0, 2'd2);
      drain();

      // Invalid layouts: zero pitch, zero height, bad mode
      program_layout(11'd5, 13'd0, 13'd480, tfsa_pkg::MSAA_1X, 1'b0, 1'b1);
      send_sample(13'd0, 13'd0, 2'd0);
      drain();
      program_layout(11'd5, 13'd640, 13'd0, tfsa_pkg::MSAA_1X, 1'b0, 1'b1);
      send_sample(13'd0, 13'd0, 2'd0);
      drain();
      write_register(CSR_UNUSED_INDEX, 13'($urandom));
      program_layout(11'd5, 13'd640, 13'd480, tfsa_pkg::MSAA_BAD, 1'b1, 1'b1);
      send_sample(13'd0, 13'd0, 2'd0);
      send_sample(13'd10, 13'd10, 2'd3);
      drain();

      // Random layouts, mostly in-range items with some noise
      for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               base = 11'd2047; pitch = 13'd8191; height = 13'd8191;
            end
            1: begin
               base = 11'd0; pitch = 13'd1; height = 13'd1;
            end
            default: begin
               base   = 11'($urandom);
               pitch  = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 8191))
                                                   : 13'($urandom_range(1, 300));
               height = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 8191))
                                                   : 13'($urandom_range(1, 300));
            end
         endcase
         mode  = ($urandom_range(0, 7) == 0) ? tfsa_pkg::MSAA_BAD
                                             : tfsa_pkg::msaa_type'($urandom_range(0, 2));
         wide  = 1'($urandom);
         depth = 1'($urandom);
         program_layout(base, pitch, height, mode, wide, depth);
         if (p == HOLD_PHASE)
            hold_armed = 1'b1;
         repeat (PHASE_SAMPLES) begin
            if ($urandom_range(0, 4) != 0 && mode != tfsa_pkg::MSAA_BAD) begin
               x = 13'($urandom_range(0, pitch - 1));
               y = 13'($urandom_range(0, height - 1));
               s = 2'($urandom_range(0, (1 << mode) - 1));
            end else begin
               x = 13'($urandom);
               y = 13'($urandom);
               s = 2'($urandom);
            end
            send_sample(x, y, s);
         end
         drain();
      end

      if (mismatch_count == 0 && addresses_in_flight == 0) begin
         $display("tiled_framebuffer_sample_address_tb: PASS");
      end else begin
         $display("tiled_framebuffer_sample_address_tb: FAIL");
      end
      $finish;
   end

endmodule
